// ----- sv/msb_first_bit_field_reader_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the MSB-first bit field reader
// Shared property forms, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_FIELD_READER_UNIT_DEFINES_SVH
`define MSB_FIRST_BIT_FIELD_READER_UNIT_DEFINES_SVH

// Same-cycle implication
`define MBFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MBFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mbfr_pkg.sv -----
// ----------------------------------------------------------------------------
// mbfr_pkg
// Types and constants shared by the bit field reader modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbfr_pkg;

    localparam int FIFO_BYTES_DEF     = 64;
    localparam int MAX_FIELD_BITS_DEF = 32;
    localparam int VALUE_W            = 32;

    // Command queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic REQ_PUSH = 1'b0;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_WIDTH = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_READ   = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_FETCH = 2'd1,
        BK_DONE  = 2'd2
    } back_state_t;

    typedef struct packed {
        cmd_kind_t  kind;
        status_t    status;
        logic [7:0] data_byte;
        logic [2:0] offset;
        logic [5:0] nbits;
        logic       le;
    } cmd_t;

endpackage

// ----- sv/mbfr_front.sv -----
// ----------------------------------------------------------------------------
// mbfr_front
// Accepts requests, checks them against the FIFO occupancy and cursor, books
// the new cursor and fill level, and queues a command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbfr_front
    import mbfr_pkg::*;
#(
    parameter int FIFO_BYTES     = FIFO_BYTES_DEF,
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF,
    parameter int IDX_W          = $clog2(FIFO_BYTES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             req_type,
    input  logic [7:0]       data_byte,
    input  logic [5:0]       field_bits,
    input  logic             little_endian,
    output logic             q_valid,
    input  logic             q_ready,
    output cmd_t             q_cmd,
    output logic [IDX_W-1:0] q_idx
);

    localparam int AVAIL_W = $clog2(FIFO_BYTES * 8 + 1);

    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [2:0]         offset_reg, offset_next;
    logic [AVAIL_W-1:0] avail_reg, avail_next;

    logic [AVAIL_W:0]   occ_bits;
    logic               full;
    logic               width_bad;
    logic               short_data;
    logic [6:0]         pos;
    logic [IDX_W:0]     rd_sum;
    logic               accept;

    always_comb
    begin
        occ_bits   = {1'b0, avail_reg} + (AVAIL_W + 1)'(offset_reg);
        full       = (occ_bits >> 3) >= (AVAIL_W + 1)'(FIFO_BYTES);
        width_bad  = ({1'b0, field_bits} > 7'(MAX_FIELD_BITS))
                     || (little_endian && (field_bits[2:0] != 3'd0));
        short_data = AVAIL_W'(field_bits) > avail_reg;
        pos        = 7'(offset_reg) + 7'(field_bits);
        rd_sum     = (IDX_W + 1)'(rd_idx_reg) + (IDX_W + 1)'(pos[6:3]);
        if (rd_sum >= (IDX_W + 1)'(FIFO_BYTES))
        begin
            rd_sum = rd_sum - (IDX_W + 1)'(FIFO_BYTES);
        end

        accept   = s_tvalid && q_ready;
        s_tready = q_ready;
        q_valid  = s_tvalid;

        q_cmd.kind      = CMD_REPORT;
        q_cmd.status    = ST_OK;
        q_cmd.data_byte = data_byte;
        q_cmd.offset    = offset_reg;
        q_cmd.nbits     = field_bits;
        q_cmd.le        = little_endian;
        q_idx           = rd_idx_reg;

        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        offset_next = offset_reg;
        avail_next  = avail_reg;

        if (req_type == REQ_PUSH)
        begin
            if (full)
            begin
                q_cmd.status = ST_FULL;
            end
            else
            begin
                q_cmd.kind = CMD_PUSH;
                q_idx      = wr_idx_reg;
                if (accept)
                begin
                    wr_idx_next = (wr_idx_reg == IDX_W'(FIFO_BYTES - 1)) ? '0
                                  : wr_idx_reg + IDX_W'(1);
                    avail_next  = avail_reg + AVAIL_W'(8);
                end
            end
        end
        else if (width_bad)
        begin
            q_cmd.status = ST_WIDTH;
        end
        else if (short_data)
        begin
            q_cmd.status = ST_SHORT;
        end
        else if (field_bits != 6'd0)
        begin
            q_cmd.kind = CMD_READ;
            if (accept)
            begin
                rd_idx_next = rd_sum[IDX_W-1:0];
                offset_next = pos[2:0];
                avail_next  = avail_reg - AVAIL_W'(field_bits);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            offset_reg <= '0;
            avail_reg  <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            offset_reg <= offset_next;
            avail_reg  <= avail_next;
        end
    end

endmodule

// ----- sv/mbfr_queue.sv -----
// ----------------------------------------------------------------------------
// mbfr_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbfr_queue
    import mbfr_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  cmd_t             push_cmd,
    input  logic [IDX_W-1:0] push_idx,
    output logic             pop_valid,
    input  logic             pop_ready,
    output cmd_t             pop_cmd,
    output logic [IDX_W-1:0] pop_idx
);

    cmd_t             cmd_q [QUEUE_DEPTH];
    logic [IDX_W-1:0] idx_q [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
        pop_valid  = count_reg != '0;
        pop_cmd    = cmd_q[rd_ptr_reg];
        pop_idx    = idx_q[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;

        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_q[wr_ptr_reg] <= push_cmd;
            idx_q[wr_ptr_reg] <= push_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/mbfr_back.sv -----
// ----------------------------------------------------------------------------
// mbfr_back
// Owns the byte store. Writes pushed bytes, fetches the bytes a field spans
// one per cycle, aligns and masks the field and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbfr_back
    import mbfr_pkg::*;
#(
    parameter int FIFO_BYTES     = FIFO_BYTES_DEF,
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF,
    parameter int IDX_W          = $clog2(FIFO_BYTES)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  cmd_t               q_cmd,
    input  logic [IDX_W-1:0]   q_idx,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] value,
    output status_t            status
);

    localparam int MAX_BYTES = (MAX_FIELD_BITS + 14) / 8;
    localparam int ACC_W     = 8 * MAX_BYTES;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int LE_B      = MAX_FIELD_BITS / 8;
    localparam int WIDE_W    = (MAX_FIELD_BITS > VALUE_W) ? MAX_FIELD_BITS : VALUE_W;

    logic [7:0] mem [FIFO_BYTES];

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [CNT_W-1:0]    issued_reg, issued_next;
    logic [CNT_W-1:0]    recv_reg, recv_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                rd_valid_reg;
    logic [7:0]          rd_data_reg;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    status_t             out_status_reg, out_status_next;

    logic                rd_en;
    logic                wr_en;
    logic                out_free;
    logic [CNT_W-1:0]    nbytes;
    logic [2:0]          tail;
    logic [ACC_W-1:0]    shifted;
    logic [MAX_FIELD_BITS-1:0] mask;
    logic [MAX_FIELD_BITS-1:0] be_val;
    logic [MAX_FIELD_BITS-1:0] le_val;
    logic [MAX_FIELD_BITS-1:0] sel_val;
    logic [WIDE_W-1:0]   wide_val;
    logic [7:0]          piece;
    logic [2:0]          pieces;

    // Field alignment: drop the unread tail bits of the last byte, then mask
    always_comb
    begin
        nbytes  = CNT_W'((7'(cmd_reg.offset) + 7'(cmd_reg.nbits) + 7'd7) >> 3);
        tail    = 3'd0 - (cmd_reg.offset + cmd_reg.nbits[2:0]);
        shifted = acc_reg >> tail;
        for (int i = 0; i < MAX_FIELD_BITS; i++)
        begin
            mask[i] = 7'(i) < 7'(cmd_reg.nbits);
        end
        be_val = MAX_FIELD_BITS'(shifted) & mask;

        // Byte-swap within the field: first piece lands in the lowest byte
        pieces = cmd_reg.nbits[5:3];
        le_val = '0;
        for (int i = 0; i < LE_B; i++)
        begin
            piece = 8'd0;
            for (int j = 0; j < LE_B; j++)
            begin
                if ((i < int'(pieces)) && (j == int'(pieces) - 1 - i))
                begin
                    piece = be_val[8*j +: 8];
                end
            end
            le_val[8*i +: 8] = piece;
        end

        sel_val  = cmd_reg.le ? le_val : be_val;
        wide_val = WIDE_W'(sel_val);
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        issued_next     = issued_reg;
        recv_next       = recv_reg;
        acc_next        = acc_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        out_free        = !out_valid_reg || m_tready;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        CMD_READ:
                        begin
                            q_pop       = 1'b1;
                            cmd_next    = q_cmd;
                            addr_next   = q_idx;
                            issued_next = '0;
                            recv_next   = '0;
                            state_next  = BK_FETCH;
                        end
                        CMD_PUSH:
                        begin
                            if (out_free)
                            begin
                                q_pop           = 1'b1;
                                wr_en           = 1'b1;
                                out_valid_next  = 1'b1;
                                out_value_next  = '0;
                                out_status_next = ST_OK;
                            end
                        end
                        CMD_REPORT:
                        begin
                            if (out_free)
                            begin
                                q_pop           = 1'b1;
                                out_valid_next  = 1'b1;
                                out_value_next  = '0;
                                out_status_next = q_cmd.status;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_FETCH:
            begin
                if (issued_reg != nbytes)
                begin
                    rd_en       = 1'b1;
                    issued_next = issued_reg + CNT_W'(1);
                    addr_next   = (addr_reg == IDX_W'(FIFO_BYTES - 1)) ? '0
                                  : addr_reg + IDX_W'(1);
                end
                if (rd_valid_reg)
                begin
                    acc_next  = {acc_reg[ACC_W-9:0], rd_data_reg};
                    recv_next = recv_reg + CNT_W'(1);
                    if (recv_next == nbytes)
                    begin
                        state_next = BK_DONE;
                    end
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = wide_val[VALUE_W-1:0];
                    out_status_next = ST_OK;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[q_idx] <= q_cmd.data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        acc_reg        <= acc_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            issued_reg    <= '0;
            recv_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            recv_reg      <= recv_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign value    = out_value_reg;
    assign status   = out_status_reg;

endmodule

// ----- sv/msb_first_bit_field_reader_unit.sv -----
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader_unit
// MSB-first bit field reader over a byte FIFO, stream in and stream out.
// ----------------------------------------------------------------------------
// Every request gives exactly one response. A push appends a byte; a read
// returns 1 to MAX_FIELD_BITS bits from the read cursor, right-aligned, and in
// little-endian mode with its 8-bit pieces swapped so the first lands lowest.
// Errors (status short, bad width, FIFO full) return 0 and change nothing. The
// front end books every request in the cycle it is taken, so the input keeps
// moving while results wait, as long as the command queue has room. Pushes and
// rejected requests pass the back end at one a cycle while the output is not
// stalled. A read holds the back end while it fetches the bytes the field
// spans: the byte store has one read port and delivers one byte per cycle.
// The store needs no clearing after reset; reads only reach pushed bytes.
`timescale 1ns / 1ps

module msb_first_bit_field_reader_unit
    import mbfr_pkg::*;
#(
    parameter int FIFO_BYTES     = FIFO_BYTES_DEF,
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // data_byte[7:0], field_bits[13:8], little_endian[14], pad
    input  logic [0:0]  s_tuser,  // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // value[31:0]
    output logic [1:0]  m_tuser   // status[1:0]
);

    localparam int IDX_W = $clog2(FIFO_BYTES);

    logic             q_in_valid;
    logic             q_in_ready;
    cmd_t             q_in_cmd;
    logic [IDX_W-1:0] q_in_idx;
    logic             q_out_valid;
    logic             q_out_pop;
    cmd_t             q_out_cmd;
    logic [IDX_W-1:0] q_out_idx;
    status_t          out_status;

    mbfr_front #(
        .FIFO_BYTES     (FIFO_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .IDX_W          (IDX_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .req_type      (s_tuser[0]),
        .data_byte     (s_tdata[7:0]),
        .field_bits    (s_tdata[13:8]),
        .little_endian (s_tdata[14]),
        .q_valid       (q_in_valid),
        .q_ready       (q_in_ready),
        .q_cmd         (q_in_cmd),
        .q_idx         (q_in_idx)
    );

    mbfr_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_cmd   (q_in_cmd),
        .push_idx   (q_in_idx),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_pop),
        .pop_cmd    (q_out_cmd),
        .pop_idx    (q_out_idx)
    );

    mbfr_back #(
        .FIFO_BYTES     (FIFO_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .IDX_W          (IDX_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_out_valid),
        .q_pop    (q_out_pop),
        .q_cmd    (q_out_cmd),
        .q_idx    (q_out_idx),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .value    (m_tdata),
        .status   (out_status)
    );

    assign m_tuser = out_status;

endmodule

// ----- sv/mbfr_checker.sv -----
// ----------------------------------------------------------------------------
// mbfr_checker
// Port-level checks on the bit field reader, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "msb_first_bit_field_reader_unit_defines.svh"

module mbfr_checker
    import mbfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Requests taken but not yet answered
    logic [2:0]  pending_reg;
    logic        in_acc;
    logic        out_acc;
    logic        out_stall;
    logic        out_err;
    logic [33:0] out_word;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign out_err   = m_tvalid && (m_tuser != ST_OK);
    assign out_word  = {m_tuser, m_tdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_acc) - 3'(out_acc);
        end
    end

    `MBFR_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "response moved")
    `MBFR_ASSERT_IMP(a_err_zero, out_err, m_tdata == 32'd0, "error response carries a value")
    `MBFR_ASSERT_IMP(a_no_invent, m_tvalid, pending_reg != 3'd0, "response with nothing pending")
    `MBFR_ASSERT_IMP(a_bounded, in_acc, pending_reg < 3'd4, "too many requests in flight")

endmodule

bind msb_first_bit_field_reader_unit mbfr_checker u_mbfr_checker (.*);
